### rtl/core/slac_pkg.sv
// shared constants, codes and types of the set associative lru cache model
package slac_pkg;

	// default storage geometry
	localparam int MAX_SETS_DEF = 64;
	localparam int MAX_WAYS_DEF = 8;

	// field widths
	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 64;
	localparam int TAG_W      = 64;
	localparam int USE_W      = 32;
	localparam int CNT_W      = 32;
	localparam int OUT_W      = 2;
	localparam int SB_W       = 3;
	localparam int BB_W       = 6;
	localparam int WAYS_W     = 4;
	localparam int RAW_SET_W  = 7;
	localparam int SHIFT_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int LINE_W     = 1 + TAG_W + USE_W;

	localparam int QUEUE_DEPTH = 2;

	// record kinds
	localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STORE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd3;

	// lookup outcomes
	localparam logic [OUT_W-1:0] OUT_NONE  = 2'd0;
	localparam logic [OUT_W-1:0] OUT_HIT   = 2'd1;
	localparam logic [OUT_W-1:0] OUT_MISS  = 2'd2;
	localparam logic [OUT_W-1:0] OUT_EVICT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	// queue status toward both sides
	typedef struct packed {
		logic full;
		logic empty;
	} slac_q_stat_t;

endpackage

### rtl/core/slac_front.sv
// front end: configuration registers, record accept and address split
module slac_front #(
	parameter int MAX_SETS = slac_pkg::MAX_SETS_DEF,
	parameter int SET_W    = 1,
	parameter int Q_W      = slac_pkg::CMD_W + SET_W + slac_pkg::TAG_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [slac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              start,
	input  logic                              busy,
	input  logic [slac_pkg::CMD_W-1:0]        cmd,
	input  logic [slac_pkg::ADDR_W-1:0]       address,
	output logic                              push,
	output logic [Q_W-1:0]                    item,
	output logic [slac_pkg::WAYS_W-1:0]       ways
);

	localparam int MOD_W = $clog2(MAX_SETS) + slac_pkg::RAW_SET_W + 1;

	logic [slac_pkg::SB_W-1:0]      set_bits_q;
	logic [slac_pkg::BB_W-1:0]      block_bits_q;
	logic [slac_pkg::WAYS_W-1:0]    ways_q;

	logic [slac_pkg::ADDR_W-1:0]    off_shifted;
	logic [slac_pkg::RAW_SET_W:0]   set_mask;
	logic [slac_pkg::RAW_SET_W-1:0] raw_set;
	logic [slac_pkg::SHIFT_W-1:0]   tag_shift;
	logic [slac_pkg::TAG_W-1:0]     tag;
	logic [MOD_W-1:0]               mod_r;
	logic [SET_W-1:0]               set_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= slac_pkg::WAYS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				slac_pkg::REG_SET_BITS:   set_bits_q   <= cfg_wdata[slac_pkg::SB_W-1:0];
				slac_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_wdata[slac_pkg::BB_W-1:0];
				slac_pkg::REG_WAYS:       ways_q       <= cfg_wdata[slac_pkg::WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// set index and tag
	always_comb begin
		off_shifted = address >> block_bits_q;
		set_mask    = (slac_pkg::RAW_SET_W+1)'((9'd1 << set_bits_q) - 9'd1);
		raw_set     = off_shifted[slac_pkg::RAW_SET_W-1:0] & set_mask[slac_pkg::RAW_SET_W-1:0];
		tag_shift   = slac_pkg::SHIFT_W'(set_bits_q) + slac_pkg::SHIFT_W'(block_bits_q);
		if (tag_shift >= slac_pkg::SHIFT_W'(slac_pkg::ADDR_W)) begin
			tag = '0;
		end else begin
			tag = address >> tag_shift;
		end
	end

	// set index modulo storage depth, restoring steps on a narrow value
	always_comb begin
		mod_r = MOD_W'(raw_set);
		for (int k = slac_pkg::RAW_SET_W - 1; k >= 0; k--) begin
			if (mod_r >= (MOD_W'(MAX_SETS) << k)) begin
				mod_r = mod_r - (MOD_W'(MAX_SETS) << k);
			end
		end
		set_idx = mod_r[SET_W-1:0];
	end

	assign push = start && !busy;
	assign item = {cmd, set_idx, tag};
	assign ways = ways_q;

endmodule

### rtl/core/slac_queue.sv
// short record queue between front end and back end
module slac_queue #(
	parameter int W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [W-1:0]          wdata,
	input  logic                  pop,
	output logic [W-1:0]          rdata,
	output slac_pkg::slac_q_stat_t stat
);

	localparam int DEPTH = slac_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign rdata      = slots_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

### rtl/core/slac_back.sv
// back end: set memory, lookup, lru victim choice, write back and counters
module slac_back #(
	parameter int MAX_SETS = slac_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = slac_pkg::MAX_WAYS_DEF,
	parameter int SET_W    = 1,
	parameter int Q_W      = slac_pkg::CMD_W + SET_W + slac_pkg::TAG_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [slac_pkg::WAYS_W-1:0]    ways,
	input  slac_pkg::slac_q_stat_t         q_stat,
	input  logic [Q_W-1:0]                 head,
	output logic                           pop,
	output logic                           clearing,
	output logic                           done,
	output logic [slac_pkg::OUT_W-1:0]     first_outcome,
	output logic [slac_pkg::OUT_W-1:0]     second_outcome,
	output logic [slac_pkg::CNT_W-1:0]     hits_total,
	output logic [slac_pkg::CNT_W-1:0]     misses_total,
	output logic [slac_pkg::CNT_W-1:0]     evictions_total
);

	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
	localparam int CMPW_W  = (WCNT_W > slac_pkg::WAYS_W) ? WCNT_W : slac_pkg::WAYS_W;
	localparam int ROW_W   = MAX_WAYS * slac_pkg::LINE_W;
	localparam int TL      = $clog2(MAX_WAYS);
	localparam int TP      = 1 << TL;
	localparam int TAG_W   = slac_pkg::TAG_W;
	localparam int USE_W   = slac_pkg::USE_W;
	localparam int CNT_W   = slac_pkg::CNT_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;
	localparam logic [1:0] ST_WB    = 2'd3;

	logic [1:0]                     state_q;
	logic [SET_W-1:0]               clr_idx_q;

	logic [ROW_W-1:0]               row_mem [MAX_SETS];
	logic [ROW_W-1:0]               row_rd_q;
	logic                           mem_we;
	logic [SET_W-1:0]               mem_waddr;
	logic [ROW_W-1:0]               mem_wdata;
	logic                           mem_re;

	logic [slac_pkg::CMD_W-1:0]     head_cmd;
	logic [SET_W-1:0]               head_set;
	logic [TAG_W-1:0]               head_tag;

	logic [slac_pkg::CMD_W-1:0]     cmd_q;
	logic [SET_W-1:0]               set_q;
	logic [TAG_W-1:0]               tag_q;
	logic [USE_W-1:0]               stamp_q;

	logic [WCNT_W-1:0]              nw;
	logic [CMPW_W-1:0]              ways_ext;
	logic [MAX_WAYS-1:0]            hit_vec;
	logic [MAX_WAYS-1:0]            inv_vec;
	logic [USE_W-1:0]               age     [MAX_WAYS];
	logic [MAX_WAYS-1:0]            hit_vec_s2;
	logic [MAX_WAYS-1:0]            inv_vec_s2;
	logic [USE_W-1:0]               age_s2  [MAX_WAYS];

	logic [USE_W-1:0]               tr_age  [0:TL][0:TP-1];
	logic [WAY_W-1:0]               tr_idx  [0:TL][0:TP-1];
	logic [WAY_W-1:0]               hit_way;
	logic [WAY_W-1:0]               inv_way;
	logic [WAY_W-1:0]               sel_way;
	logic                           hit_any;
	logic                           inv_any;
	logic [slac_pkg::OUT_W-1:0]     outcome;
	logic [ROW_W-1:0]               new_row;
	logic                           is_modify;
	logic [1:0]                     hit_inc;

	logic                           done_q;
	logic [slac_pkg::OUT_W-1:0]     first_q;
	logic [slac_pkg::OUT_W-1:0]     second_q;
	logic [CNT_W-1:0]               hit_cnt_q;
	logic [CNT_W-1:0]               miss_cnt_q;
	logic [CNT_W-1:0]               evict_cnt_q;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
	                                             input logic [1:0] d);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W+1)'(d);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	assign head_cmd = head[Q_W-1 -: slac_pkg::CMD_W];
	assign head_set = head[TAG_W +: SET_W];
	assign head_tag = head[TAG_W-1:0];

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign mem_re   = pop;

	// set memory, one row per set
	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			row_rd_q <= row_mem[head_set];
		end
	end

	// ways in use, clamped to one through the storage width
	always_comb begin
		ways_ext = CMPW_W'(ways);
		if (ways_ext == '0) begin
			nw = WCNT_W'(1);
		end else if (ways_ext > CMPW_W'(MAX_WAYS)) begin
			nw = WCNT_W'(MAX_WAYS);
		end else begin
			nw = WCNT_W'(ways_ext);
		end
	end

	// per way compare against the row just read
	always_comb begin
		for (int j = 0; j < MAX_WAYS; j++) begin
			logic                 in_use;
			logic [slac_pkg::LINE_W-1:0] ln;
			in_use     = (WCNT_W'(j) < nw);
			ln         = row_rd_q[j*slac_pkg::LINE_W +: slac_pkg::LINE_W];
			hit_vec[j] = in_use && ln[slac_pkg::LINE_W-1] && (ln[USE_W +: TAG_W] == tag_q);
			inv_vec[j] = in_use && !ln[slac_pkg::LINE_W-1];
			age[j]     = in_use ? (stamp_q - ln[USE_W-1:0]) : '0;
		end
	end

	// oldest way, ties to the lower way
	always_comb begin
		for (int lv = 0; lv <= TL; lv++) begin
			for (int n = 0; n < TP; n++) begin
				tr_age[lv][n] = '0;
				tr_idx[lv][n] = '0;
			end
		end
		for (int n = 0; n < TP; n++) begin
			tr_age[0][n] = (n < MAX_WAYS) ? age_s2[n % MAX_WAYS] : '0;
			tr_idx[0][n] = WAY_W'(n);
		end
		for (int lv = 1; lv <= TL; lv++) begin
			for (int n = 0; n < (TP >> lv); n++) begin
				if (tr_age[lv-1][2*n+1] > tr_age[lv-1][2*n]) begin
					tr_age[lv][n] = tr_age[lv-1][2*n+1];
					tr_idx[lv][n] = tr_idx[lv-1][2*n+1];
				end else begin
					tr_age[lv][n] = tr_age[lv-1][2*n];
					tr_idx[lv][n] = tr_idx[lv-1][2*n];
				end
			end
		end
	end

	// way choice and updated row
	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int j = MAX_WAYS - 1; j >= 0; j--) begin
			if (hit_vec_s2[j]) begin
				hit_way = WAY_W'(j);
			end
			if (inv_vec_s2[j]) begin
				inv_way = WAY_W'(j);
			end
		end
		hit_any = |hit_vec_s2;
		inv_any = |inv_vec_s2;
		priority if (hit_any) begin
			sel_way = hit_way;
			outcome = slac_pkg::OUT_HIT;
		end else if (inv_any) begin
			sel_way = inv_way;
			outcome = slac_pkg::OUT_MISS;
		end else begin
			sel_way = tr_idx[TL][0];
			outcome = slac_pkg::OUT_EVICT;
		end
		new_row = row_rd_q;
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (WAY_W'(j) == sel_way) begin
				new_row[j*slac_pkg::LINE_W +: slac_pkg::LINE_W] = {1'b1, tag_q, stamp_q};
			end
		end
		// the second lookup of a modify always hits the line the first one left
		is_modify = (cmd_q == slac_pkg::CMD_MODIFY);
		hit_inc   = 2'(hit_any) + 2'(is_modify);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_q;
		mem_wdata = new_row;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (state_q == ST_WB) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
			set_q <= head_set;
			tag_q <= head_tag;
		end
		if (state_q == ST_EVAL) begin
			hit_vec_s2 <= hit_vec;
			inv_vec_s2 <= inv_vec;
			for (int j = 0; j < MAX_WAYS; j++) begin
				age_s2[j] <= age[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			stamp_q     <= '0;
			done_q      <= 1'b0;
			first_q     <= slac_pkg::OUT_NONE;
			second_q    <= slac_pkg::OUT_NONE;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_W'(1);
					if (clr_idx_q == SET_W'(MAX_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						unique case (head_cmd)
							slac_pkg::CMD_FETCH: begin
								done_q   <= 1'b1;
								first_q  <= slac_pkg::OUT_NONE;
								second_q <= slac_pkg::OUT_NONE;
								stamp_q  <= stamp_q + USE_W'(1);
							end
							slac_pkg::CMD_LOAD, slac_pkg::CMD_STORE,
							slac_pkg::CMD_MODIFY: begin
								state_q <= ST_EVAL;
							end
						endcase
					end
				end
				ST_EVAL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					done_q      <= 1'b1;
					first_q     <= outcome;
					second_q    <= is_modify ? slac_pkg::OUT_HIT : slac_pkg::OUT_NONE;
					hit_cnt_q   <= sat_add(hit_cnt_q, hit_inc);
					miss_cnt_q  <= sat_add(miss_cnt_q, 2'(!hit_any));
					evict_cnt_q <= sat_add(evict_cnt_q, 2'(!hit_any && !inv_any));
					stamp_q     <= stamp_q + USE_W'(1);
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign first_outcome   = first_q;
	assign second_outcome  = second_q;
	assign hits_total      = hit_cnt_q;
	assign misses_total    = miss_cnt_q;
	assign evictions_total = evict_cnt_q;

endmodule

### rtl/core/set_assoc_lru_cache_model_unit.sv
// a load, store or modify result strobes after its set read, compare and write back steps,
// a fetch result is registered as it leaves the queue; the back end takes one record at a time,
// and a 2 entry queue lets start transfer while the back end works
// reset: asynchronous, clears control and counters, then a clearing pass writes every set
// row, one row a cycle, with busy high; config writes are taken meanwhile
// results are never held off: done strobes one cycle per record
module set_assoc_lru_cache_model_unit #(
	parameter int MAX_SETS = slac_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = slac_pkg::MAX_WAYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic [slac_pkg::CMD_W-1:0]      cmd,
	input  logic [slac_pkg::ADDR_W-1:0]     address,
	output logic                            done,
	output logic [slac_pkg::OUT_W-1:0]      first_outcome,
	output logic [slac_pkg::OUT_W-1:0]      second_outcome,
	output logic [slac_pkg::CNT_W-1:0]      hits_total,
	output logic [slac_pkg::CNT_W-1:0]      misses_total,
	output logic [slac_pkg::CNT_W-1:0]      evictions_total
);

	// set index width follows the storage depth
	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	// queue entry: command, set index, full tag
	localparam int Q_W   = slac_pkg::CMD_W + SET_W + slac_pkg::TAG_W;

	logic                           push;
	logic                           pop;
	logic                           clearing;
	logic [Q_W-1:0]                 item;
	logic [Q_W-1:0]                 head;
	logic [slac_pkg::WAYS_W-1:0]    ways;
	slac_pkg::slac_q_stat_t         q_stat;

	// hold off transfers while the queue is full or the set rows are being cleared
	assign busy = q_stat.full || clearing;

	// front end splits the address under the current geometry
	slac_front #(
		.MAX_SETS (MAX_SETS),
		.SET_W    (SET_W),
		.Q_W      (Q_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.address   (address),
		.push      (push),
		.item      (item),
		.ways      (ways)
	);

	// records waiting for the back end
	slac_queue #(
		.W (Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	// back end runs one record at a time against the set memory
	slac_back #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.SET_W    (SET_W),
		.Q_W      (Q_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ways            (ways),
		.q_stat          (q_stat),
		.head            (head),
		.pop             (pop),
		.clearing        (clearing),
		.done            (done),
		.first_outcome   (first_outcome),
		.second_outcome  (second_outcome),
		.hits_total      (hits_total),
		.misses_total    (misses_total),
		.evictions_total (evictions_total)
	);

`ifndef SYNTHESIS
	// running counts move only with a result strobe
	a_counts_move_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable({hits_total, misses_total, evictions_total}))
		else $error("counts changed without a result");

	// one record adds at most one miss
	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(misses_total - $past(misses_total)) <= 32'd1))
		else $error("miss count jumped by more than one");

	// a second lookup exists only for a modify and always hits
	a_second_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && second_outcome != slac_pkg::OUT_NONE) |->
		(second_outcome == slac_pkg::OUT_HIT && first_outcome != slac_pkg::OUT_NONE))
		else $error("bad second outcome");

	// no transfer is taken while the set rows are being cleared
	a_no_push_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("record taken during clearing pass");
`endif

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the set associative lru cache model unit
module testbench;
	import slac_pkg::*;

	// one line slot per way of every set, the same storage as the block's default geometry
	localparam int LINES = MAX_SETS_DEF * MAX_WAYS_DEF;
	// index past the register list, the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// number of random phases and records per phase
	localparam int PHASES = 9;
	localparam int PHASE_RECORDS = 85;
	localparam int POOL_MAX = 12;

	// expected content of one result transfer
	typedef struct packed {
		logic [OUT_W-1:0] first;
		logic [OUT_W-1:0] second;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evictions;
	} cache_report_t;

	// shadow copy of the cache: predicts one report per accepted record and
	// compares every result transfer against the oldest report still waiting
	class cache_tracker;
		bit              valid_q [LINES];
		bit [TAG_W-1:0]  tag_q   [LINES];
		bit [USE_W-1:0]  used_q  [LINES];
		bit [USE_W-1:0]  stamp;
		bit [CNT_W-1:0]  hits, misses, evictions;
		bit [SB_W-1:0]   set_bits_q;
		bit [BB_W-1:0]   block_bits_q;
		bit [WAYS_W-1:0] ways_q;
		cache_report_t   waiting_reports [$];
		int unsigned     mismatches;

		function new();
			ways_q = 1;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SET_BITS:   set_bits_q   = data[SB_W-1:0];
				REG_BLOCK_BITS: block_bits_q = data[BB_W-1:0];
				REG_WAYS:       ways_q       = data[WAYS_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		// one set lookup with lru fill or replacement
		function logic [OUT_W-1:0] probe(logic [ADDR_W-1:0] addr);
			int unsigned nw, set_no, base, victim, sh;
			logic [ADDR_W-1:0] set_mask, tag;
			bit [USE_W-1:0] age, oldest;
			nw = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways_q);
			set_mask = (64'd1 << set_bits_q) - 1;
			set_no = ((addr >> block_bits_q) & set_mask) % MAX_SETS_DEF;
			sh = set_bits_q + block_bits_q;
			tag = (sh >= ADDR_W) ? '0 : (addr >> sh);
			base = set_no * MAX_WAYS_DEF;
			for (int j = 0; j < nw; j++) begin
				if (valid_q[base + j] && tag_q[base + j] == tag) begin
					hits = bump(hits);
					used_q[base + j] = stamp;
					return OUT_HIT;
				end
			end
			misses = bump(misses);
			for (int j = 0; j < nw; j++) begin
				if (!valid_q[base + j]) begin
					valid_q[base + j] = 1'b1;
					tag_q[base + j] = tag;
					used_q[base + j] = stamp;
					return OUT_MISS;
				end
			end
			evictions = bump(evictions);
			victim = 0;
			oldest = 0;
			for (int j = 0; j < nw; j++) begin
				age = stamp - used_q[base + j];
				if (age > oldest) begin
					oldest = age;
					victim = j;
				end
			end
			tag_q[base + victim] = tag;
			used_q[base + victim] = stamp;
			return OUT_EVICT;
		endfunction

		function void note_record(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] addr);
			cache_report_t r;
			r.first = OUT_NONE;
			r.second = OUT_NONE;
			if (c != CMD_FETCH) begin
				r.first = probe(addr);
				if (c == CMD_MODIFY)
					r.second = probe(addr);
			end
			stamp = stamp + 1;
			r.hits = hits;
			r.misses = misses;
			r.evictions = evictions;
			waiting_reports.push_back(r);
		endfunction

		function void check_report(cache_report_t got);
			cache_report_t want;
			if (waiting_reports.size() == 0) begin
				$error("result transfer with no record waiting");
				mismatches++;
				return;
			end
			want = waiting_reports.pop_front();
			if (got.first !== want.first) begin
				$error("first_outcome: expected %0d, actual %0d", want.first, got.first);
				mismatches++;
			end
			if (got.second !== want.second) begin
				$error("second_outcome: expected %0d, actual %0d", want.second, got.second);
				mismatches++;
			end
			if (got.hits !== want.hits) begin
				$error("hits_total: expected %0d, actual %0d", want.hits, got.hits);
				mismatches++;
			end
			if (got.misses !== want.misses) begin
				$error("misses_total: expected %0d, actual %0d", want.misses, got.misses);
				mismatches++;
			end
			if (got.evictions !== want.evictions) begin
				$error("evictions_total: expected %0d, actual %0d", want.evictions,
					got.evictions);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return waiting_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	logic                  busy;
	logic [CMD_W-1:0]      cmd;
	logic [ADDR_W-1:0]     address;
	logic                  done;
	logic [OUT_W-1:0]      first_outcome;
	logic [OUT_W-1:0]      second_outcome;
	logic [CNT_W-1:0]      hits_total;
	logic [CNT_W-1:0]      misses_total;
	logic [CNT_W-1:0]      evictions_total;

	cache_tracker tracker;

	// geometry as the block sees it, used to aim addresses at chosen sets and tags
	int unsigned       geo_sb, geo_bb, geo_ways;
	logic [ADDR_W-1:0] tag_pool [POOL_MAX];
	int unsigned       pool_n;
	int unsigned       hot_set;

	// raw register data per random phase; some values carry bits the block must mask off
	logic [CFG_DATA_W-1:0] phase_sb   [PHASES] = '{6'd2, 6'd6, 6'h3F, 6'd0, 6'd7,
		6'd3, 6'd1, 6'd4, 6'h38};
	logic [CFG_DATA_W-1:0] phase_bb   [PHASES] = '{6'd3, 6'd58, 6'd2, 6'd0, 6'd63,
		6'd6, 6'd12, 6'd5, 6'd40};
	logic [CFG_DATA_W-1:0] phase_ways [PHASES] = '{6'd4, 6'd8, 6'd15, 6'd1, 6'd0,
		6'h39, 6'd3, 6'h32, 6'd5};

	set_assoc_lru_cache_model_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.address         (address),
		.done            (done),
		.first_outcome   (first_outcome),
		.second_outcome  (second_outcome),
		.hits_total      (hits_total),
		.misses_total    (misses_total),
		.evictions_total (evictions_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs on a transfer
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// result transfers: done strobes one cycle, sampled at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_report({first_outcome, second_outcome, hits_total,
				misses_total, evictions_total});
	end

	// single register write; the caller lowers cfg_we after the last one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.apply_reg(idx, data);
	endtask

	// all three registers back to back, plus a stray write past the register list
	task automatic set_geometry(logic [CFG_DATA_W-1:0] sbv, logic [CFG_DATA_W-1:0] bbv,
		logic [CFG_DATA_W-1:0] wv);
		write_reg(REG_SET_BITS, sbv);
		write_reg(REG_BLOCK_BITS, bbv);
		write_reg(REG_WAYS, wv);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		geo_sb = sbv[SB_W-1:0];
		geo_bb = bbv[BB_W-1:0];
		geo_ways = (wv[WAYS_W-1:0] == 0) ? 1 :
			((wv[WAYS_W-1:0] > MAX_WAYS_DEF) ? MAX_WAYS_DEF : wv[WAYS_W-1:0]);
	endtask

	// hold start high until the record transfers; start stays high for a back to back record
	task automatic send_record(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a);
		start <= 1'b1;
		cmd <= c;
		address <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_record(c, a);
	endtask

	// sender idle gap with the given chance in percent
	task automatic maybe_pause(int unsigned pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	// stop sending and let every predicted result come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] compose_address(logic [ADDR_W-1:0] tag,
		logic [ADDR_W-1:0] set_no, logic [ADDR_W-1:0] offset);
		int unsigned sh;
		logic [ADDR_W-1:0] omask, smask;
		sh = geo_sb + geo_bb;
		omask = (64'd1 << geo_bb) - 1;
		smask = (64'd1 << geo_sb) - 1;
		return ((sh >= ADDR_W) ? '0 : (tag << sh)) | ((set_no & smask) << geo_bb) |
			(offset & omask);
	endfunction

	// mostly tags from a pool a little larger than the associativity, on a couple of
	// hot sets, so hits, fills and evictions all come up; the rest is raw noise
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] set_no, offset;
		if ($urandom_range(0, 99) < 15)
			return {$urandom, $urandom};
		set_no = ($urandom_range(0, 3) == 0) ? $urandom : hot_set + $urandom_range(0, 1);
		offset = {$urandom, $urandom};
		return compose_address(tag_pool[$urandom_range(0, pool_n - 1)], set_no, offset);
	endfunction

	initial begin
		int unsigned pct;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		cmd = CMD_FETCH;
		address = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed records on two sets of two ways, 16 byte blocks
		set_geometry(6'd1, 6'd4, 6'd2);
		send_record(CMD_FETCH, '0);
		send_record(CMD_LOAD, '0);
		send_record(CMD_LOAD, '1);
		send_record(CMD_LOAD, '0);
		send_record(CMD_STORE, compose_address(64'd1, 64'd0, 64'd3));
		// set full: modify evicts the older line, then hits on the one it just filled
		send_record(CMD_MODIFY, compose_address(64'd2, 64'd0, 64'd0));
		send_record(CMD_LOAD, '0);
		send_record(CMD_FETCH, '1);
		send_record(CMD_STORE, compose_address(64'd2, 64'd0, 64'd15));
		send_record(CMD_MODIFY, compose_address(64'd2, 64'd0, 64'd1));
		send_record(CMD_MODIFY, '1);
		send_record(CMD_LOAD, compose_address(64'd5, 64'd1, 64'd0));
		send_record(CMD_LOAD, compose_address(64'd6, 64'd1, 64'd0));
		send_record(CMD_STORE, compose_address(64'd5, 64'd1, 64'd7));
		send_record(CMD_MODIFY, compose_address('1, 64'd1, 64'd9));
		send_record(CMD_FETCH, 64'h5555_5555_5555_5555);
		send_record(CMD_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
		drain();

		// random phases, each under a new geometry; stored lines carry over between them
		for (int p = 0; p < PHASES; p++) begin
			pct = (p < 3) ? 22 : ((p < 6) ? 72 : 0);
			set_geometry(phase_sb[p], phase_bb[p], phase_ways[p]);
			pool_n = geo_ways + $urandom_range(0, 3);
			for (int k = 0; k < POOL_MAX; k++)
				tag_pool[k] = ($urandom_range(0, 1) == 0) ? 64'(k) : {$urandom, $urandom};
			hot_set = $urandom;
			for (int n = 0; n < PHASE_RECORDS; n++) begin
				send_record(CMD_W'($urandom_range(0, 3)), pick_address());
				maybe_pause(pct);
			end
			drain();
		end

		// extra cycles to catch any stray result transfer
		repeat (12)
			@(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d predicted results never arrived", tracker.pending());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
rtl/core/slac_pkg.sv
rtl/core/slac_front.sv
rtl/core/slac_queue.sv
rtl/core/slac_back.sv
rtl/core/set_assoc_lru_cache_model_unit.sv
tb/sv/testbench.sv
